### design/rdiv_pkg.sv
`default_nettype none

package rdiv_pkg;

  // Quotient and remainder widths are fixed by the 32-bit divisor.
  localparam int QUO_BITS = 32;
  localparam int REM_BITS = 32;

  localparam logic [QUO_BITS-1:0] QUO_ALL_ONES = {QUO_BITS{1'b1}};
  localparam logic [QUO_BITS-1:0] QUO_ZERO     = '0;

  // Control that travels down the pipe next to the payload.
  typedef struct packed {
    logic valid;
    logic sat;
  } rdiv_ctl_t;

endpackage

`default_nettype wire

### design/rdiv_stage.sv
`default_nettype none

module rdiv_stage import rdiv_pkg::*; #(
  parameter int DVD_BITS = 50,
  parameter int BIT_POS  = 49
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rdiv_ctl_t           ctl_in,
  input  wire logic [REM_BITS-1:0] rem_in,
  input  wire logic [DVD_BITS-1:0] dvd_in,
  input  wire logic [QUO_BITS-1:0] quo_in,
  input  wire logic [REM_BITS-1:0] dsr_in,
  output rdiv_ctl_t                ctl_q,
  output logic      [REM_BITS-1:0] rem_q,
  output logic      [DVD_BITS-1:0] dvd_q,
  output logic      [QUO_BITS-1:0] quo_q,
  output logic      [REM_BITS-1:0] dsr_q
);

  logic [REM_BITS:0]   shifted;
  logic [REM_BITS:0]   diff;
  logic                ge;
  logic                valid_r;
  logic                sat_r;
  logic                sat_nxt;
  logic [REM_BITS-1:0] rem_r;
  logic [REM_BITS-1:0] rem_nxt;
  logic [DVD_BITS-1:0] dvd_r;
  logic [QUO_BITS-1:0] quo_r;
  logic [QUO_BITS-1:0] quo_nxt;
  logic [REM_BITS-1:0] dsr_r;

  // One restoring step: bring down the next dividend bit, try the subtract.
  assign shifted = {rem_in, dvd_in[DVD_BITS-1]};
  assign ge      = (shifted >= {1'b0, dsr_in});
  assign diff    = shifted - {1'b0, dsr_in};
  // remainder stays below the divisor, so it fits 32 bits
  assign rem_nxt = ge ? diff[REM_BITS-1:0] : shifted[REM_BITS-1:0];

  generate
    if (BIT_POS < QUO_BITS) begin : g_quo
      assign quo_nxt = {quo_in[QUO_BITS-2:0], ge};
      assign sat_nxt = ctl_in.sat;
    end else begin : g_sat
      assign quo_nxt = quo_in;
      assign sat_nxt = ctl_in.sat | ge;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    sat_r <= sat_nxt;
    rem_r <= rem_nxt;
    dvd_r <= {dvd_in[DVD_BITS-2:0], 1'b0};
    quo_r <= quo_nxt;
    dsr_r <= dsr_in;
  end

  assign ctl_q.valid = valid_r;
  assign ctl_q.sat   = sat_r;
  assign rem_q       = rem_r;
  assign dvd_q       = dvd_r;
  assign quo_q       = quo_r;
  assign dsr_q       = dsr_r;

endmodule

`default_nettype wire

### design/rounded_divide_50_by_32.sv
`default_nettype none

// Rounded unsigned divider: {in_dividend_high, in_dividend_low} / in_divisor.
//
// Input channel: a transfer happens at a rising edge with start high and busy
// low. busy is held low; the pipe takes a new division every cycle.
// Result channel: out_valid strobes for one cycle with out_quotient; the
// receiver cannot hold it off and nothing here ever needs it to.
//
// Pipeline: throughput is one division per cycle, as busy is never raised.
// Depth is set by the restoring loop: one register stage per dividend bit,
// each a single 33-bit compare/subtract, then a rounding compare stage and a
// select/increment stage, whose registers drive the outputs.
//
// Results: divisor zero gives zero; a quotient bit at or above bit 32
// saturates to all ones (no rounding); otherwise round half up when twice the
// remainder reaches the divisor, unless the quotient is already all ones.
//
// Reset (synchronous, rst_n low) clears every valid bit, so transfers in
// flight are dropped and no stray strobe follows. Data registers are not reset.
module rounded_divide_50_by_32 import rdiv_pkg::*; #(
  parameter int DIVIDEND_BITS = 50
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [DIVIDEND_BITS-33:0]  in_dividend_high,
  input  wire logic [QUO_BITS-1:0]        in_dividend_low,
  input  wire logic [REM_BITS-1:0]        in_divisor,
  output logic                            out_valid,
  output logic      [QUO_BITS-1:0]        out_quotient
);

  localparam int NSTAGE = DIVIDEND_BITS;

  // Stage boundaries: index 0 is the input ports, index k+1 the output of step k.
  rdiv_ctl_t                  ctl_s [0:NSTAGE];
  logic [REM_BITS-1:0]        rem_s [0:NSTAGE];
  logic [DIVIDEND_BITS-1:0]   dvd_s [0:NSTAGE];
  logic [QUO_BITS-1:0]        quo_s [0:NSTAGE];
  logic [REM_BITS-1:0]        dsr_s [0:NSTAGE];

  // Rounding stage registers.
  logic                valid_a_r;
  logic                sat_a_r;
  logic                dz_a_r;
  logic                up_a_r;
  logic [QUO_BITS-1:0] quo_a_r;
  logic                up_a_nxt;

  // Output registers.
  logic                out_valid_r;
  logic [QUO_BITS-1:0] out_quotient_r;
  logic [QUO_BITS-1:0] out_quotient_nxt;

  // Never back-pressures the issuer.
  assign busy = 1'b0;

  assign ctl_s[0].valid = start & ~busy;
  assign ctl_s[0].sat   = 1'b0;
  assign rem_s[0]       = '0;
  assign dvd_s[0]       = {in_dividend_high, in_dividend_low};
  assign quo_s[0]       = '0;
  assign dsr_s[0]       = in_divisor;

  // Step k handles dividend bit DIVIDEND_BITS-1-k, MSB first.
  generate
    for (genvar k = 0; k < NSTAGE; k++) begin : g_step
      rdiv_stage #(
        .DVD_BITS (DIVIDEND_BITS),
        .BIT_POS  (DIVIDEND_BITS - 1 - k)
      ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (ctl_s[k]),
        .rem_in (rem_s[k]),
        .dvd_in (dvd_s[k]),
        .quo_in (quo_s[k]),
        .dsr_in (dsr_s[k]),
        .ctl_q  (ctl_s[k+1]),
        .rem_q  (rem_s[k+1]),
        .dvd_q  (dvd_s[k+1]),
        .quo_q  (quo_s[k+1]),
        .dsr_q  (dsr_s[k+1])
      );
    end
  endgenerate

  // rem >= ceil(d/2)  <=>  2*rem >= d; keeps the compare at 33 bits.
  assign up_a_nxt = ({rem_s[NSTAGE], 1'b0} >= {1'b0, dsr_s[NSTAGE]}) &&
                    (quo_s[NSTAGE] != QUO_ALL_ONES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= ctl_s[NSTAGE].valid;
    end
  end

  always_ff @(posedge clk) begin
    sat_a_r <= ctl_s[NSTAGE].sat;
    dz_a_r  <= (dsr_s[NSTAGE] == '0);
    up_a_r  <= up_a_nxt;
    quo_a_r <= quo_s[NSTAGE];
  end

  // Divisor zero wins over saturation; saturation skips rounding.
  always_comb begin
    priority if (dz_a_r) begin
      out_quotient_nxt = QUO_ZERO;
    end else if (sat_a_r) begin
      out_quotient_nxt = QUO_ALL_ONES;
    end else begin
      out_quotient_nxt = quo_a_r + {{(QUO_BITS-1){1'b0}}, up_a_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    out_quotient_r <= out_quotient_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_quotient = out_quotient_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------

  // Every strobe traces back to a matching input transfer through the whole pipe.
  a_strobe_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, DIVIDEND_BITS + 2))
    else $error("result strobe without matching input transfer");

  // A saturated, nonzero-divisor item leaves as all ones.
  a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_a_r && sat_a_r && !dz_a_r) |=> (out_valid && out_quotient == QUO_ALL_ONES))
    else $error("saturated quotient not all ones");

  // Rounding never wraps an all-ones quotient back to zero.
  a_no_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_a_r && up_a_r) |-> (quo_a_r != QUO_ALL_ONES))
    else $error("round-up requested on all-ones quotient");

endmodule

`default_nettype wire
